// ===== design/pnc_pkg.sv =====
// shared types and constants for the perfect number checker
// used by perfect_number_check, pnc_div and pnc_chk; depends on nothing
`default_nettype none

package pnc_pkg;

    // default width of the number field
    localparam int NUMBER_WIDTH_DEF = 16;

    // width of the reported sums
    localparam int SUM_WIDTH = 19;

    // extra accumulator bits above the number width, enough for the divisor sum
    localparam int ACC_MARGIN = 4;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_ACC_D,
        S_ACC_Q,
        S_SUB,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== design/pnc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on pnc_pkg for the default width
`default_nettype none

module pnc_div #(
    parameter int NUMBER_WIDTH = pnc_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [NUMBER_WIDTH-1:0] i_dividend,
    input  wire logic [NUMBER_WIDTH-1:0] i_divisor,
    output logic      [NUMBER_WIDTH-1:0] o_quotient,
    output logic      [NUMBER_WIDTH-1:0] o_remainder,
    output logic                         o_done
);

    localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

    logic [NUMBER_WIDTH-1:0] r_rem;
    logic [NUMBER_WIDTH-1:0] r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [NUMBER_WIDTH:0]   shifted;
    logic [NUMBER_WIDTH:0]   diff;
    logic                    fits;

    // next partial remainder with the top dividend bit shifted in
    always_comb begin
        shifted = {r_rem, r_quo[NUMBER_WIDTH-1]};
        diff    = shifted - {1'b0, i_divisor};
        fits    = ~diff[NUMBER_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUMBER_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[NUMBER_WIDTH-1:0] : shifted[NUMBER_WIDTH-1:0];
            r_quo <= {r_quo[NUMBER_WIDTH-2:0], fits};
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

`default_nettype wire

// ===== design/perfect_number_check.sv =====
// top level of the perfect number checker: divisor-pair sequencer and result register
// depends on pnc_pkg and pnc_div
//
// usage:
//   input channel  i_in_valid / o_in_stall carries i_number; a request is taken
//   when i_in_valid is high and o_in_stall is low
//   output channel o_out_valid / i_out_stall carries o_divisor_sum, o_proper_sum
//   and o_is_perfect, one result per request, in order
// timing:
//   divisors are tried in pairs d and n/d for d = 1 up to sqrt(n); each trial is
//   one pass of the bit-serial divider plus, when d divides n, the accumulate
//   states S_ACC_D and S_ACC_Q (only S_ACC_D if d = n/d); the divider sets the pace
//   a request of zero goes straight to the result with all fields zero
//   one request is worked on at a time; the next is taken as soon as the
//   previous result sits in the output register
// stall and reset:
//   a result held by i_out_stall stays stable in the output register; a finished
//   result waits in the sequencer until that register frees up
//   synchronous active-low reset empties the output register and returns the
//   sequencer to idle; there is no other state to clear
//   sums beyond 19 bits (only at wider NUMBER_WIDTH) saturate
`default_nettype none

module perfect_number_check #(
    parameter int NUMBER_WIDTH = pnc_pkg::NUMBER_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [NUMBER_WIDTH-1:0]      i_number,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [pnc_pkg::SUM_WIDTH-1:0] o_divisor_sum,
    output logic      [pnc_pkg::SUM_WIDTH-1:0] o_proper_sum,
    output logic                              o_is_perfect
);

    import pnc_pkg::*;

    // accumulator wide enough for the exact divisor sum
    localparam int ACC_W = NUMBER_WIDTH + ACC_MARGIN;
    // common width for the saturation compare
    localparam int EXT_W = (ACC_W > SUM_WIDTH) ? ACC_W : SUM_WIDTH;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

    t_state r_state;
    t_state n_state;

    logic [NUMBER_WIDTH-1:0] r_n;      // number under test
    logic [NUMBER_WIDTH-1:0] r_d;      // current trial divisor
    logic [ACC_W-1:0]        r_total;  // running sum of all divisors
    logic [ACC_W-1:0]        r_proper; // total minus the number

    logic                    r_out_valid;
    logic [SUM_WIDTH-1:0]    r_out_div;
    logic [SUM_WIDTH-1:0]    r_out_prop;
    logic                    r_out_perf;

    // divider interface
    logic                    div_start;
    logic                    div_done;
    logic [NUMBER_WIDTH-1:0] div_quo;
    logic [NUMBER_WIDTH-1:0] div_rem;

    // decoded controls
    logic                    in_stall;
    logic                    in_take;
    logic                    out_load;
    logic                    slot_free;

    // result formatting
    logic [EXT_W-1:0]        total_ext;
    logic [EXT_W-1:0]        proper_ext;
    logic [SUM_WIDTH-1:0]    total_sat;
    logic [SUM_WIDTH-1:0]    proper_sat;
    logic                    perfect;

    pnc_div #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_n),
        .i_divisor   (r_d),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_done      (div_done)
    );

    // output register frees up this cycle if empty or being taken
    assign slot_free = ~r_out_valid | ~i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // zero has no divisors, go straight to the result
                    n_state = (i_number == '0) ? S_SUB : S_START;
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    if (div_quo < r_d) begin
                        // past the square root, every pair has been seen
                        n_state = S_SUB;
                    end else if (div_rem == '0) begin
                        n_state = S_ACC_D;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_ACC_D: begin
                // a square root divisor counts once
                n_state = (div_quo == r_d) ? S_START : S_ACC_Q;
            end
            S_ACC_Q: begin
                n_state = S_START;
            end
            S_SUB: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state-decoded controls
    always_comb begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_stall = 1'b0;
            end
            S_START: begin
                div_start = 1'b1;
            end
            S_OUT: begin
                out_load = slot_free;
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign in_take = i_in_valid & ~in_stall;

    // saturate sums to the output width; perfection uses the exact sum
    always_comb begin
        total_ext  = EXT_W'(r_total);
        proper_ext = EXT_W'(r_proper);
        total_sat  = (total_ext > EXT_W'(SUM_MAX)) ? SUM_MAX : total_ext[SUM_WIDTH-1:0];
        proper_sat = (proper_ext > EXT_W'(SUM_MAX)) ? SUM_MAX : proper_ext[SUM_WIDTH-1:0];
        perfect    = (r_proper == ACC_W'(r_n)) && (r_n != '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_n     <= i_number;
                    r_d     <= NUMBER_WIDTH'(1);
                    r_total <= '0;
                end
            end
            S_WAIT: begin
                // non-divisor: move on to the next candidate
                if (div_done && div_quo >= r_d && div_rem != '0) begin
                    r_d <= r_d + NUMBER_WIDTH'(1);
                end
            end
            S_ACC_D: begin
                r_total <= r_total + ACC_W'(r_d);
                if (div_quo == r_d) begin
                    r_d <= r_d + NUMBER_WIDTH'(1);
                end
            end
            S_ACC_Q: begin
                r_total <= r_total + ACC_W'(div_quo);
                r_d     <= r_d + NUMBER_WIDTH'(1);
            end
            S_SUB: begin
                r_proper <= r_total - ACC_W'(r_n);
            end
            default: begin
                r_d <= r_d;
            end
        endcase
    end

    // output register payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_div  <= total_sat;
            r_out_prop <= proper_sat;
            r_out_perf <= perfect;
        end
    end

    assign o_in_stall    = in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_divisor_sum = r_out_div;
    assign o_proper_sum  = r_out_prop;
    assign o_is_perfect  = r_out_perf;

endmodule

`default_nettype wire

// ===== design/pnc_chk.sv =====
// port-level checker for perfect_number_check, attached by bind
// depends on pnc_pkg for the sum width
`default_nettype none

module pnc_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [pnc_pkg::SUM_WIDTH-1:0] o_divisor_sum,
    input wire logic [pnc_pkg::SUM_WIDTH-1:0] o_proper_sum,
    input wire logic                          o_is_perfect
);

    import pnc_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_divisor_sum) && $stable(o_proper_sum)
            && $stable(o_is_perfect))
        else $error("stalled result changed");

    // a taken request closes the input right after it is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a request");

    // a new result only appears while a request is in flight
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request");

    // proper sum never exceeds the full divisor sum
    a_sum_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_proper_sum <= o_divisor_sum)
        else $error("proper sum above divisor sum");

    // a perfect number has a divisor sum of twice its proper sum
    a_perfect_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_perfect && !o_proper_sum[SUM_WIDTH-1] |->
            o_divisor_sum == {o_proper_sum[SUM_WIDTH-2:0], 1'b0})
        else $error("perfect flag inconsistent with sums");

endmodule

bind perfect_number_check pnc_chk u_pnc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_divisor_sum (o_divisor_sum),
    .o_proper_sum  (o_proper_sum),
    .o_is_perfect  (o_is_perfect)
);

`default_nettype wire
